/* src/fqd_pkg.sv */
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared constants, types and helpers for the handle queue with delete.
// ----------------------------------------------------------------------------
package fqd_pkg;

  // queue geometry
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int OFF_W       = PTR_W + 1;
  localparam int SUM_W       = PTR_W + 2;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // request codes
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_DEL  = 2'd2,
    REQ_ITER = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ZERO     = 3'd4
  } status_e;

  // control sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEQ   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_ITER  = 5'b10000
  } state_e;

  // ram write port
  typedef struct packed {
    logic                   en;
    logic [PTR_W-1:0]       addr;
    logic [VALUE_WIDTH-1:0] data;
  } wr_t;

  // physical slot of a logical position in the ring
  function automatic logic [PTR_W-1:0] fqd_wrap(logic [PTR_W-1:0] base,
                                                logic [OFF_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* src/fqd_ram.sv */
// ----------------------------------------------------------------------------
// fqd_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fqd_ram
  import fqd_pkg::*;
(
  input  logic                   clk_i,
  input  wr_t                    wr_i,
  input  logic [PTR_W-1:0]       raddr_i,
  output logic [VALUE_WIDTH-1:0] rdata_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/fifo_queue_with_delete_core.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_core
// Ordered queue of nonzero handles held in a ring in one synchronous RAM,
// with enqueue, dequeue, delete by value and iterate.
//
//   channel   | ports                                       | handshake
//   ----------+---------------------------------------------+------------------
//   request   | req_type_i, value_i                         | start && !busy
//   result    | status_o, item_value_o, count_o, last_o     | done_o strobe
//
// Enqueue and every refused or empty-queue request are answered straight
// from idle; dequeue waits in S_DEQ for the front entry. Delete reads the
// ring one entry a cycle from the front and, on a hit, writes each later
// entry back one slot forward as it is read, so it reads every entry whether
// it hits or misses. Iterate emits one result a cycle, front to rear. Reset
// clears the control state and the count; the RAM keeps its contents.
// Results are held one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_core
  import fqd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [VALUE_WIDTH-1:0] item_value_o,
  output logic [CNT_W-1:0]       count_o,
  output logic                   last_o
);

  state_e                 state_q, state_d;
  logic [PTR_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [PTR_W-1:0]       idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;

  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic [VALUE_WIDTH-1:0] item_q, item_d;
  logic [CNT_W-1:0]       ocnt_q, ocnt_d;
  logic                   last_q, last_d;

  wr_t                    wr;
  logic [PTR_W-1:0]       raddr;
  logic [VALUE_WIDTH-1:0] rdata;

  logic [OFF_W-1:0]       idx_nx;
  logic                   is_last;
  logic                   full;
  req_e                   req;

  // entry store
  fqd_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // position helpers
  assign idx_nx  = OFF_W'(idx_q) + OFF_W'(1);
  assign is_last = (idx_nx == OFF_W'(cnt_q));
  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign req     = req_e'(req_type_i);

  // sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    val_d    = val_q;
    done_d   = 1'b0;
    status_d = ST_OK;
    item_d   = '0;
    ocnt_d   = cnt_q;
    last_d   = 1'b1;
    wr       = '0;
    raddr    = fqd_wrap(head_q, idx_nx);

    unique case (state_q)
      S_IDLE: begin
        raddr = head_q;
        if (start) begin
          val_d = value_i;
          idx_d = '0;
          unique case (req)
            REQ_ENQ: begin
              done_d = 1'b1;
              if (value_i == '0) begin
                status_d = ST_ZERO;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                wr.en   = 1'b1;
                wr.addr = fqd_wrap(head_q, OFF_W'(cnt_q));
                wr.data = value_i;
                cnt_d   = cnt_q + CNT_W'(1);
                ocnt_d  = cnt_q + CNT_W'(1);
              end
            end
            REQ_DEQ: begin
              if (cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d = S_DEQ;
              end
            end
            REQ_DEL: begin
              if (value_i == '0) begin
                done_d   = 1'b1;
                status_d = ST_ZERO;
              end else if (cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_NOTFOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_ITER: begin
              if (cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d = S_ITER;
              end
            end
          endcase
        end
      end

      // front entry arrives: hand it out and advance the head
      S_DEQ: begin
        done_d  = 1'b1;
        item_d  = rdata;
        cnt_d   = cnt_q - CNT_W'(1);
        ocnt_d  = cnt_q - CNT_W'(1);
        head_d  = fqd_wrap(head_q, OFF_W'(1));
        state_d = S_IDLE;
      end

      // compare one entry a cycle, next read already issued
      S_SCAN: begin
        if (rdata == val_q) begin
          if (is_last) begin
            done_d  = 1'b1;
            cnt_d   = cnt_q - CNT_W'(1);
            ocnt_d  = cnt_q - CNT_W'(1);
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_nx[PTR_W-1:0];
            state_d = S_SHIFT;
          end
        end else if (is_last) begin
          done_d   = 1'b1;
          status_d = ST_NOTFOUND;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_nx[PTR_W-1:0];
        end
      end

      // close the gap: entry read at idx goes back to idx-1
      S_SHIFT: begin
        wr.en   = 1'b1;
        wr.addr = fqd_wrap(head_q, OFF_W'(idx_q) - OFF_W'(1));
        wr.data = rdata;
        if (is_last) begin
          done_d  = 1'b1;
          cnt_d   = cnt_q - CNT_W'(1);
          ocnt_d  = cnt_q - CNT_W'(1);
          state_d = S_IDLE;
        end else begin
          idx_d = idx_nx[PTR_W-1:0];
        end
      end

      // one result per entry, front to rear
      S_ITER: begin
        done_d = 1'b1;
        item_d = rdata;
        last_d = is_last;
        if (is_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_nx[PTR_W-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    status_q <= status_d;
    item_q   <= item_d;
    ocnt_q   <= ocnt_d;
    last_q   <= last_d;
  end

  // result transfer
  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign item_value_o = item_q;
  assign count_o      = ocnt_q;
  assign last_o       = last_q;

endmodule
